### rtl/modexp_pkg.sv
// Shared constants for the modular exponentiation pipeline.
package modexp_pkg;

    localparam int unsigned RES_W = 30;

    localparam logic [RES_W-1:0] PRIME = 30'd1000000007;

    localparam logic [63:0] MU_WIDE = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] MU = MU_WIDE[30:0];

    localparam logic [RES_W-1:0] ONE = 30'd1;

endpackage

### rtl/modexp_mulmod.sv
// Four-stage modular multiplier with Barrett reduction by the fixed prime.
module modexp_mulmod
    import modexp_pkg::*;
#(
    parameter int unsigned SIDE_W = 61
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [RES_W-1:0]     a_in,
    input  logic [RES_W-1:0]     b_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 valid_out,
    output logic [RES_W-1:0]     prod_out,
    output logic [SIDE_W-1:0]    side_out
);

    logic [3:0]        valid_reg;
    logic [59:0]       x1_reg;
    logic [31:0]       x2_reg;
    logic [30:0]       q3_reg;
    logic [31:0]       x3_reg;
    logic [31:0]       m3_reg;
    logic [RES_W-1:0]  prod_reg;
    logic [SIDE_W-1:0] side1_reg;
    logic [SIDE_W-1:0] side2_reg;
    logic [SIDE_W-1:0] side3_reg;
    logic [SIDE_W-1:0] side4_reg;

    logic [61:0]       q2_next;
    logic [60:0]       m_next;
    logic [31:0]       r;
    logic [31:0]       r_p;
    logic [31:0]       r_2p;
    logic [RES_W-1:0]  prod_next;

    assign q2_next = 62'(x1_reg[59:29]) * 62'(MU);
    assign m_next  = 61'(q3_reg) * 61'(PRIME);
    assign r       = x3_reg - m3_reg;
    assign r_p     = r - 32'(PRIME);
    assign r_2p    = r - {1'b0, PRIME, 1'b0};

    always_comb begin
        if (r >= {1'b0, PRIME, 1'b0}) begin
            prod_next = r_2p[RES_W-1:0];
        end else if (r >= 32'(PRIME)) begin
            prod_next = r_p[RES_W-1:0];
        end else begin
            prod_next = r[RES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], valid_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg    <= 60'(a_in) * 60'(b_in);
            side1_reg <= side_in;
            x2_reg    <= x1_reg[31:0];
            q3_reg    <= q2_next[61:31];
            side2_reg <= side1_reg;
            x3_reg    <= x2_reg;
            m3_reg    <= m_next[31:0];
            side3_reg <= side2_reg;
            prod_reg  <= prod_next;
            side4_reg <= side3_reg;
        end
    end

    assign valid_out = valid_reg[3];
    assign prod_out  = prod_reg;
    assign side_out  = side4_reg;

endmodule

### rtl/modexp_cell.sv
// One exponent bit: square the running value, then multiply by the base if the bit is set.
module modexp_cell
    import modexp_pkg::*;
#(
    parameter int unsigned EXP_BITS = 31,
    parameter int unsigned BIT_POS  = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                valid_in,
    input  logic [RES_W-1:0]    acc_in,
    input  logic [RES_W-1:0]    base_in,
    input  logic [EXP_BITS-1:0] exp_in,
    output logic                valid_out,
    output logic [RES_W-1:0]    acc_out,
    output logic [RES_W-1:0]    base_out,
    output logic [EXP_BITS-1:0] exp_out
);

    localparam int unsigned SIDE_W = RES_W + EXP_BITS;

    logic                sq_valid;
    logic [RES_W-1:0]    sq_acc;
    logic [SIDE_W-1:0]   sq_side;
    logic [SIDE_W-1:0]   mul_side;
    logic [RES_W-1:0]    mul_b;
    logic [RES_W-1:0]    sq_base;
    logic [EXP_BITS-1:0] sq_exp;

    modexp_mulmod #(.SIDE_W(SIDE_W)) u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (valid_in),
        .a_in      (acc_in),
        .b_in      (acc_in),
        .side_in   ({exp_in, base_in}),
        .valid_out (sq_valid),
        .prod_out  (sq_acc),
        .side_out  (sq_side)
    );

    assign sq_base = sq_side[RES_W-1:0];
    assign sq_exp  = sq_side[SIDE_W-1:RES_W];
    assign mul_b   = sq_exp[BIT_POS] ? sq_base : ONE;

    modexp_mulmod #(.SIDE_W(SIDE_W)) u_multiply (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (sq_valid),
        .a_in      (sq_acc),
        .b_in      (mul_b),
        .side_in   (sq_side),
        .valid_out (valid_out),
        .prod_out  (acc_out),
        .side_out  (mul_side)
    );

    assign base_out = mul_side[RES_W-1:0];
    assign exp_out  = mul_side[SIDE_W-1:RES_W];

endmodule

### rtl/modular_exponentiation.sv
// Top level: base to the exponent modulo 1000000007 through a chain of bit cells.
//
// Every item runs through one input stage that reduces the base, then one cell per
// exponent bit from the most significant down; each cell holds two four-stage modular
// multipliers (square, then conditional multiply). One item enters every cycle while the
// output is not stalled; a stalled output holds the whole pipeline.
module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int unsigned EXP_BITS = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // base [30:0], exponent [61:31], zero [63:62]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // power_mod [29:0], zero [31:30]
);

    logic                en;
    logic                pre_valid_reg;
    logic [RES_W-1:0]    pre_base_reg;
    logic [EXP_BITS-1:0] pre_exp_reg;
    logic [30:0]         base_raw;
    logic [31:0]         base_p;
    logic [31:0]         base_2p;
    logic [RES_W-1:0]    base_next;
    logic [62:0]         exp_ext;

    logic                c_valid [EXP_BITS+1];
    logic [RES_W-1:0]    c_acc   [EXP_BITS+1];
    logic [RES_W-1:0]    c_base  [EXP_BITS+1];
    logic [EXP_BITS-1:0] c_exp   [EXP_BITS+1];

    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    assign base_raw = s_tdata[30:0];
    assign exp_ext  = 63'(s_tdata[61:31]);
    assign base_p   = 32'(base_raw) - 32'(PRIME);
    assign base_2p  = 32'(base_raw) - {1'b0, PRIME, 1'b0};

    always_comb begin
        if (32'(base_raw) >= {1'b0, PRIME, 1'b0}) begin
            base_next = base_2p[RES_W-1:0];
        end else if (32'(base_raw) >= 32'(PRIME)) begin
            base_next = base_p[RES_W-1:0];
        end else begin
            base_next = base_raw[RES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (en) begin
            pre_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_base_reg <= base_next;
            pre_exp_reg  <= exp_ext[EXP_BITS-1:0];
        end
    end

    assign c_valid[0] = pre_valid_reg;
    assign c_acc[0]   = ONE;
    assign c_base[0]  = pre_base_reg;
    assign c_exp[0]   = pre_exp_reg;

    for (genvar i = 0; i < EXP_BITS; i++) begin : g_cell
        modexp_cell #(
            .EXP_BITS (EXP_BITS),
            .BIT_POS  (EXP_BITS - 1 - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (c_valid[i]),
            .acc_in    (c_acc[i]),
            .base_in   (c_base[i]),
            .exp_in    (c_exp[i]),
            .valid_out (c_valid[i+1]),
            .acc_out   (c_acc[i+1]),
            .base_out  (c_base[i+1]),
            .exp_out   (c_exp[i+1])
        );
    end

    assign m_tvalid = c_valid[EXP_BITS];
    assign m_tdata  = {2'b00, c_acc[EXP_BITS]};

`ifndef SYNTHESIS
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29:0] < PRIME))
        else $error("result not reduced");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> (!s_tready ##1 (m_tvalid && $stable(m_tdata))))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !pre_valid_reg)
        else $error("input stage valid after reset");
`endif

endmodule
